[hw/rtl/lfk_pkg.sv]
// Shared types, constants and codes for the leg forward kinematics block.
// No dependencies; every other file of the block but lfk_stream_if imports this package.
package lfk_pkg;

   localparam int LEG_MAX     = 6;
   localparam int ANG_W       = 16;
   localparam int POS_W       = 16;
   localparam int LEN_W       = 16;
   localparam int LINK_W      = 3 * LEN_W;
   localparam int LEG_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 64;
   localparam int TRIG_W      = 17;
   localparam int QUEUE_DEPTH = 4;

   // quarter-wave sine polynomial coefficients, Q30
   localparam logic [30:0] SIN_A = 31'd1686629713;
   localparam logic [29:0] SIN_B = 30'd688904866;
   localparam logic [26:0] SIN_C = 27'd76016977;

   localparam logic [ANG_W-1:0] QUARTER_TURN = 16'h4000;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LINK    = 3'd0,
      CSR_POSE0   = 3'd1,
      CSR_POSE1   = 3'd2,
      CSR_POSE2   = 3'd3,
      CSR_POSE3   = 3'd4,
      CSR_POSE4   = 3'd5,
      CSR_POSE5   = 3'd6,
      CSR_PRESENT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LEG_W-1:0] leg_num;
      logic [ANG_W-1:0] yaw_angle;
      logic [ANG_W-1:0] pitch_angle;
      logic [ANG_W-1:0] bend_angle;
   } req_type;

   typedef struct packed {
      logic signed [POS_W-1:0] body_x;
      logic signed [POS_W-1:0] body_y;
      logic signed [POS_W-1:0] body_z;
      logic                    status;
   } rsp_type;

   typedef struct packed {
      logic                    absent;
      logic [ANG_W-1:0]        femur;
      logic [ANG_W-1:0]        knee;
      logic [ANG_W-1:0]        heading;
      logic signed [POS_W-1:0] off_x;
      logic signed [POS_W-1:0] off_y;
      logic signed [POS_W-1:0] off_z;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_status_type;

endpackage

[hw/rtl/lfk_stream_if.sv]
// Valid/ready stream interface with a typed payload.
// No dependencies; the payload type is given at instantiation.
interface lfk_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/lfk_sine.sv]
// Five-stage pipelined Q15 sine of a 16-bit binary angle.
// Depends on lfk_pkg for the polynomial coefficients.
module lfk_sine (
   input  logic                              clock,
   input  logic                              en,
   input  logic [lfk_pkg::ANG_W-1:0]         ang,
   output logic signed [lfk_pkg::TRIG_W-1:0] sin_q15
);
   import lfk_pkg::*;

   logic [14:0]        x0_ff, x0_in, x1_ff, x2x_ff, x3_ff;
   logic [3:0]         neg_ff;
   logic [29:0]        sq;
   logic [30:0]        x2_in, x2_ff, x2b_ff;
   logic [57:0]        p1;
   logic [29:0]        y1_in, y1_ff;
   logic [60:0]        p2;
   logic [30:0]        y2_in, y2_ff;
   logic [45:0]        p3;
   logic [32:0]        sr;
   logic [17:0]        q;
   logic [TRIG_W-1:0]  mag;
   logic signed [TRIG_W-1:0] out_in, out_ff;

   assign x0_in = ang[14] ? 15'd16384 - {1'b0, ang[13:0]} : {1'b0, ang[13:0]};
   assign sq    = x0_ff * x0_ff;
   assign x2_in = {sq[28:0], 2'b00};
   assign p1    = 58'(SIN_C) * 58'(x2_ff);
   assign y1_in = SIN_B - {2'b00, p1[57:30]};
   assign p2    = 61'(y1_ff) * 61'(x2b_ff);
   assign y2_in = SIN_A - p2[60:30];
   assign p3    = 46'(y2_ff) * 46'(x3_ff);
   assign sr    = {1'b0, p3[45:14]} + 33'd16384;
   assign q     = sr[32:15];
   assign mag   = (q > 18'd32768) ? 17'd32768 : q[TRIG_W-1:0];
   assign out_in = neg_ff[3] ? -$signed(mag) : $signed(mag);

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff  <= x0_in;
         x1_ff  <= x0_ff;
         x2_ff  <= x2_in;
         x2x_ff <= x1_ff;
         x2b_ff <= x2_ff;
         y1_ff  <= y1_in;
         x3_ff  <= x2x_ff;
         y2_ff  <= y2_in;
         neg_ff <= {neg_ff[2:0], ang[15]};
         out_ff <= out_in;
      end
   end

   assign sin_q15 = out_ff;
endmodule

[hw/rtl/lfk_front.sv]
// Front end: configuration registers, leg classification and job build.
// Depends on lfk_pkg and lfk_stream_if; feeds the job queue.
module lfk_front #(
   parameter int LEG_COUNT = lfk_pkg::LEG_MAX
) (
   input  logic                              clock,
   input  logic                              reset,
   lfk_stream_if.sink                        req,
   input  logic                              csr_we,
   input  logic [lfk_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [lfk_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  lfk_pkg::queue_status_type         queue_status,
   output logic                              push,
   output lfk_pkg::job_type                  job,
   output logic [lfk_pkg::LINK_W-1:0]        link_lengths
);
   import lfk_pkg::*;

   logic [LINK_W-1:0]     link_ff;
   logic [CSR_DATA_W-1:0] pose_ff [LEG_COUNT];
   logic [LEG_MAX-1:0]    present_ff;
   logic [CSR_DATA_W-1:0] pose;
   logic                  present;

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff    <= '0;
         present_ff <= '1;
         for (int i = 0; i < LEG_COUNT; i++) pose_ff[i] <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_LINK:    link_ff    <= csr_wdata[LINK_W-1:0];
            CSR_PRESENT: present_ff <= csr_wdata[LEG_MAX-1:0];
            default: begin
               for (int i = 0; i < LEG_COUNT; i++)
                  if (csr_index == CSR_IDX_W'(i + 1)) pose_ff[i] <= csr_wdata;
            end
         endcase
      end
   end

   always_comb begin
      pose    = '0;
      present = 1'b0;
      for (int i = 0; i < LEG_COUNT; i++) begin
         if (req.data.leg_num == LEG_W'(i)) begin
            pose    = pose_ff[i];
            present = present_ff[i];
         end
      end
   end

   always_comb begin
      job.absent  = !present;
      job.femur   = req.data.pitch_angle;
      job.knee    = req.data.pitch_angle + req.data.bend_angle;
      job.heading = req.data.yaw_angle + pose[63:48];
      job.off_x   = pose[15:0];
      job.off_y   = pose[31:16];
      job.off_z   = pose[47:32];
   end

   assign req.ready    = !queue_status.full;
   assign push         = req.valid && !queue_status.full;
   assign link_lengths = link_ff;
endmodule

[hw/rtl/lfk_queue.sv]
// Short job queue between the front end and the kinematics pipeline.
// Depends on lfk_pkg for the job type and depth.
module lfk_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  lfk_pkg::job_type          push_job,
   input  logic                      pop,
   output lfk_pkg::job_type          head,
   output lfk_pkg::queue_status_type queue_status
);
   import lfk_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   job_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]   count_ff, count_in;

   assign wr_in    = push ? wr_ff + 1'b1 : wr_ff;
   assign rd_in    = pop ? rd_ff + 1'b1 : rd_ff;
   assign count_in = count_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_job;
   end

   assign head               = entry_ff[rd_ff];
   assign queue_status.empty = (count_ff == '0);
   assign queue_status.full  = (count_ff == (PTR_W+1)'(QUEUE_DEPTH));
endmodule

[hw/rtl/lfk_back.sv]
// Kinematics pipeline: six sine units, link projections, heading turn,
// rounding, offset and saturation. Depends on lfk_pkg, lfk_sine, lfk_stream_if.
module lfk_back (
   input  logic                          clock,
   input  logic                          reset,
   input  lfk_pkg::job_type              head,
   input  lfk_pkg::queue_status_type     queue_status,
   input  logic [lfk_pkg::LINK_W-1:0]    link_lengths,
   output logic                          pop,
   lfk_stream_if.source                  rsp
);
   import lfk_pkg::*;

   localparam int TRIG_STAGES = 5;
   localparam int LAST        = TRIG_STAGES + 3;

   typedef struct packed {
      logic                    absent;
      logic signed [POS_W-1:0] off_x;
      logic signed [POS_W-1:0] off_y;
      logic signed [POS_W-1:0] off_z;
   } side_type;

   logic                     en;
   logic [LAST:0]            valid_ff;
   side_type                 side_ff [LAST];
   side_type                 side_in;
   logic signed [TRIG_W-1:0] cf, sf, ck, sk, ch, sh;
   logic signed [TRIG_W-1:0] ch_a_ff, sh_a_ff, ch_b_ff, sh_b_ff;
   logic signed [LEN_W:0]    lc, lf, lt;
   logic signed [33:0]       pfc_ff, ptc_ff, pfs_ff, pts_ff;
   logic signed [35:0]       reach_ff;
   logic signed [34:0]       height_ff, zr_ff;
   logic signed [52:0]       xr_ff, yr_ff, xt, yt;
   logic signed [34:0]       zt;
   logic signed [23:0]       xs, ys, zs;
   rsp_type                  out_ff, out_in;

   function automatic logic [POS_W-1:0] sat16(input logic signed [23:0] v);
      if (v > 24'sd32767) return 16'h7FFF;
      else if (v < -24'sd32768) return 16'h8000;
      else return v[POS_W-1:0];
   endfunction

   assign en  = !valid_ff[LAST] || rsp.ready;
   assign pop = en && !queue_status.empty;

   assign side_in.absent = head.absent;
   assign side_in.off_x  = head.off_x;
   assign side_in.off_y  = head.off_y;
   assign side_in.off_z  = head.off_z;

   lfk_sine u_cf (.clock, .en, .ang(head.femur + QUARTER_TURN),   .sin_q15(cf));
   lfk_sine u_sf (.clock, .en, .ang(head.femur),                  .sin_q15(sf));
   lfk_sine u_ck (.clock, .en, .ang(head.knee + QUARTER_TURN),    .sin_q15(ck));
   lfk_sine u_sk (.clock, .en, .ang(head.knee),                   .sin_q15(sk));
   lfk_sine u_ch (.clock, .en, .ang(head.heading + QUARTER_TURN), .sin_q15(ch));
   lfk_sine u_sh (.clock, .en, .ang(head.heading),                .sin_q15(sh));

   assign lc = $signed({1'b0, link_lengths[15:0]});
   assign lf = $signed({1'b0, link_lengths[31:16]});
   assign lt = $signed({1'b0, link_lengths[47:32]});

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAST-1:0], pop};
      end
   end

   assign xt = xr_ff + 53'sd536870912;
   assign yt = yr_ff + 53'sd536870912;
   assign zt = zr_ff + 35'sd16384;
   assign xs = 24'($signed(xt[52:30])) + 24'(side_ff[LAST-1].off_x);
   assign ys = 24'($signed(yt[52:30])) + 24'(side_ff[LAST-1].off_y);
   assign zs = 24'($signed(zt[34:15])) + 24'(side_ff[LAST-1].off_z);

   always_comb begin
      if (side_ff[LAST-1].absent) begin
         out_in = '0;
         out_in.status = 1'b1;
      end else begin
         out_in.body_x = sat16(xs);
         out_in.body_y = sat16(ys);
         out_in.body_z = sat16(zs);
         out_in.status = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < LAST; i++) side_ff[i] <= side_ff[i-1];
         pfc_ff    <= 34'(lf * cf);
         ptc_ff    <= 34'(lt * ck);
         pfs_ff    <= 34'(lf * sf);
         pts_ff    <= 34'(lt * sk);
         ch_a_ff   <= ch;
         sh_a_ff   <= sh;
         reach_ff  <= 36'(lc) * 36'sd32768 + 36'(pfc_ff) + 36'(ptc_ff);
         height_ff <= 35'(pfs_ff) + 35'(pts_ff);
         ch_b_ff   <= ch_a_ff;
         sh_b_ff   <= sh_a_ff;
         xr_ff     <= 53'(reach_ff) * 53'(ch_b_ff);
         yr_ff     <= 53'(reach_ff) * 53'(sh_b_ff);
         zr_ff     <= height_ff;
         out_ff    <= out_in;
      end
   end

   assign rsp.valid = valid_ff[LAST];
   assign rsp.data  = out_ff;
endmodule

[hw/rtl/leg_forward_kinematics.sv]
// Leg forward kinematics, top level: front end, job queue, pipeline.
// Depends on lfk_pkg, lfk_stream_if, lfk_front, lfk_queue, lfk_back.
//
// req carries a leg number and three joint angles; rsp returns the foot
// position in the body frame (0.1 mm, saturated) and a status bit that is
// set, with the position zeroed, when the leg is absent.
// csr writes link lengths, mount poses and the present mask; register i
// is written at csr_index i while csr_we is high.
// One beat is taken every cycle while rsp is not stalled, set by the fully
// pipelined sine units and multipliers of the back end.
// A four-entry job queue decouples req from rsp: when rsp stalls the
// pipeline holds, the queue fills and req.ready drops only once it is full.
// Reset clears the pipeline and queue and returns registers to their reset
// values (zero lengths and poses, all legs present).
module leg_forward_kinematics #(
   parameter int LEG_COUNT = lfk_pkg::LEG_MAX
) (
   input  logic                           clock,
   input  logic                           reset,
   lfk_stream_if.sink                     req,
   lfk_stream_if.source                   rsp,
   input  logic                           csr_we,
   input  logic [lfk_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lfk_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import lfk_pkg::*;

   queue_status_type  queue_status;
   job_type           push_job, head;
   logic              push, pop;
   logic [LINK_W-1:0] link_lengths;

   lfk_front #(.LEG_COUNT(LEG_COUNT)) u_front (
      .clock, .reset, .req, .csr_we, .csr_index, .csr_wdata,
      .queue_status, .push, .job(push_job), .link_lengths
   );

   lfk_queue u_queue (
      .clock, .reset, .push, .push_job, .pop, .head, .queue_status
   );

   lfk_back u_back (
      .clock, .reset, .head, .queue_status, .link_lengths, .pop, .rsp
   );

`ifndef SYNTHESIS
   a_absent_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.data.status |->
         rsp.data.body_x == 0 && rsp.data.body_y == 0 && rsp.data.body_z == 0)
      else $error("absent leg beat carries a nonzero position");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result beat right after reset");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      queue_status.empty |-> !pop)
      else $error("pop from empty job queue");
`endif
endmodule
